[src/history_match_thread_picker_core_defines.svh]
// Assertion macros for the history match thread picker.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef HISTORY_MATCH_THREAD_PICKER_CORE_DEFINES_SVH
`define HISTORY_MATCH_THREAD_PICKER_CORE_DEFINES_SVH

// property must hold at every clock outside reset
`define HMTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition must never be true outside reset
`define HMTP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

[src/hmtp_pkg.sv]
// Shared types and constants for the history match thread picker.
// No dependencies; imported by the lane, merge and top modules.
package hmtp_pkg;

    localparam int THREAD_COUNT   = 4;
    localparam int TW             = $clog2(THREAD_COUNT);
    localparam int CNT_W          = $clog2(THREAD_COUNT);
    localparam int PC_W           = 64;
    localparam int CFG_W          = 5;
    localparam int HIST_DEPTH_DEF = 16;
    localparam int DEPTH_RESET    = 8;

    typedef logic [PC_W-1:0]         pc_t;
    typedef logic [THREAD_COUNT-1:0] tmask_t;
    typedef logic [TW-1:0]           tidx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MERGE,
        ST_PICK
    } state_t;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic   found;
        tmask_t active;
        tidx_t  leader;
        logic   leader_valid;
        tidx_t  qpos_next;
    } pick_t;

endpackage

[src/hmtp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hmtp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/hmtp_lane.sv]
// One history lane: a thread's PC ring, its write pointer and valid bits,
// and the compare of each ring entry against every other thread's PC. Uses hmtp_pkg, hmtp_ram.
module hmtp_lane import hmtp_pkg::*; #(
    parameter int LANE       = 0,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF,
    localparam int AW        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1,
    localparam int DW        = $clog2(HIST_DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  lane_ctrl_t    ctrl,
    input  logic [AW-1:0] rd_addr,
    input  logic [DW-1:0] depth,
    input  pc_t           pcs [THREAD_COUNT],
    output tmask_t        hits
);

    logic [AW-1:0]         wptr_reg;
    logic [AW-1:0]         wptr_next;
    logic [AW-1:0]         wr_ptr;
    logic [DW-1:0]         wr_inc;
    logic [HIST_DEPTH-1:0] vld_reg;
    logic                  vld_rd_reg;
    logic                  cmp_vld_reg;
    tmask_t                hits_reg;
    tmask_t                hit_now;
    pc_t                   rdata;
    pc_t                   hist_word;

    hmtp_ram #(
        .WIDTH(PC_W),
        .DEPTH(HIST_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ctrl.wr_en),
        .waddr(wr_ptr),
        .wdata(pcs[LANE]),
        .re   (ctrl.rd_en),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    always_comb begin
        wr_ptr    = (DW'(wptr_reg) >= depth) ? '0 : wptr_reg;
        wr_inc    = DW'(wr_ptr) + DW'(1);
        wptr_next = (wr_inc == depth) ? '0 : AW'(wr_inc);
        hist_word = vld_rd_reg ? rdata : '0;
        for (int k = 0; k < THREAD_COUNT; k++) begin
            hit_now[k] = (k != LANE) && (hist_word == pcs[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg    <= '0;
            vld_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= ctrl.rd_en;
            if (ctrl.wr_en) begin
                wptr_reg        <= wptr_next;
                vld_reg[wr_ptr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            vld_rd_reg <= vld_reg[rd_addr];
        end
        if (ctrl.clear) begin
            hits_reg <= '0;
        end else if (cmp_vld_reg) begin
            hits_reg <= hits_reg | hit_now;
        end
    end

    assign hits = hits_reg;

endmodule

[src/hmtp_merge.sv]
// Merge stage: priorities and pending set from the lane hit vectors, and
// leader selection with the activation mask. Uses hmtp_pkg.
module hmtp_merge import hmtp_pkg::*; (
    input  tmask_t hits [THREAD_COUNT],
    input  tmask_t ign,
    input  tmask_t pending,
    input  tidx_t  qpos,
    input  pc_t    pcs [THREAD_COUNT],
    output tmask_t pending_new,
    output pick_t  pick
);

    logic [CNT_W-1:0] prio [THREAD_COUNT];
    logic [CNT_W-1:0] best;
    logic             any;
    tidx_t            sel;
    pc_t              lead_pc;

    always_comb begin
        best = '0;
        any  = 1'b0;
        for (int k = 0; k < THREAD_COUNT; k++) begin
            prio[k] = '0;
            for (int i = 0; i < THREAD_COUNT; i++) begin
                prio[k] = prio[k] + CNT_W'(hits[i][k]);
            end
        end
        for (int k = 0; k < THREAD_COUNT; k++) begin
            if (!ign[k] && (!any || prio[k] > best)) begin
                best = prio[k];
                any  = 1'b1;
            end
        end
        for (int k = 0; k < THREAD_COUNT; k++) begin
            pending_new[k] = !ign[k] && (prio[k] == best);
        end
    end

    always_comb begin
        pick = '0;
        sel  = '0;
        for (int j = THREAD_COUNT - 1; j >= 0; j--) begin
            if (pending[j] && (TW'(j) >= qpos)) begin
                sel        = TW'(j);
                pick.found = 1'b1;
            end
        end
        lead_pc = pcs[sel];
        for (int i = 0; i < THREAD_COUNT; i++) begin
            pick.active[i] = pick.found && !ign[i] && (TW'(i) >= sel)
                             && (pcs[i] == lead_pc);
        end
        for (int i = THREAD_COUNT - 1; i >= 0; i--) begin
            if (pick.active[i]) begin
                pick.leader       = TW'(i);
                pick.leader_valid = 1'b1;
            end
        end
        pick.qpos_next = (sel == TW'(THREAD_COUNT - 1)) ? '0 : sel + TW'(1);
    end

endmodule

[src/history_match_thread_picker_core.sv]
// A request accepted at queue position zero scans the history (SCAN, DRAIN, MERGE), then goes
//   to PICK; otherwise it goes straight to PICK. A PICK that finds nothing at a nonzero position
//   rescans. One request at a time: s_ready is high only in IDLE. d is the clamped history depth;
//   the scan reads d ring entries, one per cycle, from each lane's single-read history RAM.
// Reset: queue, pending set, write pointers and history valid bits clear (rings read as
//   zero); history depth returns to 8. No clearing pass.
`include "history_match_thread_picker_core_defines.svh"

module history_match_thread_picker_core import hmtp_pkg::*; #(
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  pc_t              s_pc_thread0,
    input  pc_t              s_pc_thread1,
    input  pc_t              s_pc_thread2,
    input  pc_t              s_pc_thread3,
    input  tmask_t           s_ignore_mask,
    output logic             m_valid,
    input  logic             m_ready,
    output tmask_t           m_active_mask,
    output tidx_t            m_leader_index,
    output logic             m_leader_valid
);

    localparam int AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int DW = $clog2(HIST_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_RST =
        (DEPTH_RESET > HIST_DEPTH) ? DW'(HIST_DEPTH) : DW'(DEPTH_RESET);

    function automatic logic [DW-1:0] clamp_depth(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (int'(v) > HIST_DEPTH) begin
            return DW'(HIST_DEPTH);
        end else begin
            return DW'(v);
        end
    endfunction

    state_t        state_reg;
    state_t        state_next;
    logic [DW-1:0] depth_reg;
    pc_t           pcs_reg [THREAD_COUNT];
    tmask_t        ign_reg;
    tmask_t        pending_reg;
    tidx_t         qpos_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          m_valid_reg;
    tmask_t        m_active_reg;
    tidx_t         m_leader_reg;
    logic          m_leader_valid_reg;

    tmask_t        hits [THREAD_COUNT];
    tmask_t        pending_new;
    pick_t         pick;
    lane_ctrl_t    lane_ctrl [THREAD_COUNT];
    logic          accept;
    logic          scan_start;
    logic          scan_last;
    logic          out_free;
    logic          out_load;
    logic          rescan;
    logic          leader_hit;

    for (genvar g = 0; g < THREAD_COUNT; g++) begin : g_lane
        hmtp_lane #(
            .LANE      (g),
            .HIST_DEPTH(HIST_DEPTH)
        ) u_lane (
            .aclk   (aclk),
            .aresetn(aresetn),
            .ctrl   (lane_ctrl[g]),
            .rd_addr(rd_addr_reg),
            .depth  (depth_reg),
            .pcs    (pcs_reg),
            .hits   (hits[g])
        );
    end

    hmtp_merge u_merge (
        .hits       (hits),
        .ign        (ign_reg),
        .pending    (pending_reg),
        .qpos       (qpos_reg),
        .pcs        (pcs_reg),
        .pending_new(pending_new),
        .pick       (pick)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (qpos_reg == '0) ? ST_SCAN : ST_PICK;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end else if (rescan) begin
                    state_next = ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        cfg_ready  = 1'b1;
        accept     = s_valid && s_ready;
        out_free   = !m_valid_reg || m_ready;
        scan_last  = (DW'(rd_addr_reg) == (depth_reg - DW'(1)));
        out_load   = (state_reg == ST_PICK) && out_free
                     && (pick.found || (qpos_reg == '0));
        rescan     = (state_reg == ST_PICK) && !pick.found && (qpos_reg != '0);
        scan_start = (accept && (qpos_reg == '0)) || rescan;
        for (int i = 0; i < THREAD_COUNT; i++) begin
            lane_ctrl[i].clear = scan_start;
            lane_ctrl[i].rd_en = (state_reg == ST_SCAN);
            lane_ctrl[i].wr_en = out_load && pick.active[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            depth_reg          <= DEPTH_RST;
            pending_reg        <= '0;
            qpos_reg           <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                depth_reg <= clamp_depth(cfg_data);
            end
            if (state_reg == ST_MERGE) begin
                pending_reg <= pending_new;
            end else if (out_load) begin
                pending_reg <= pending_reg & ~pick.active;
            end
            if (out_load) begin
                qpos_reg <= pick.found ? pick.qpos_next : '0;
            end else if (rescan) begin
                qpos_reg <= '0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pcs_reg[0] <= s_pc_thread0;
            pcs_reg[1] <= s_pc_thread1;
            pcs_reg[2] <= s_pc_thread2;
            pcs_reg[3] <= s_pc_thread3;
            ign_reg    <= s_ignore_mask;
        end
        if (scan_start) begin
            rd_addr_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            rd_addr_reg <= rd_addr_reg + AW'(1);
        end
        if (out_load) begin
            m_active_reg       <= pick.active;
            m_leader_reg       <= pick.leader;
            m_leader_valid_reg <= pick.leader_valid;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_active_mask  = m_active_reg;
    assign m_leader_index = m_leader_reg;
    assign m_leader_valid = m_leader_valid_reg;
    assign leader_hit     = m_active_mask[m_leader_index];

    `HMTP_ASSERT(a_leader_active, m_valid && m_leader_valid |-> leader_hit, "leader inactive")
    `HMTP_ASSERT_NEVER(a_ign_active, out_load && |(pick.active & ign_reg), "ignored activated")
    `HMTP_ASSERT(a_pend_clear, out_load |=> !(|(pending_reg & $past(pick.active))), "still pending")
    `HMTP_ASSERT(a_scan_depth, state_reg == ST_SCAN |-> DW'(rd_addr_reg) < depth_reg, "scan overrun")

endmodule
